/* rtl/mts_pkg.sv */
`timescale 1ns / 1ps

package mts_pkg;

  localparam int NUM_TAPES  = 2;
  localparam int TAPE_DEPTH = 1024;
  localparam int POS_W      = $clog2(TAPE_DEPTH);
  localparam int SYM_W      = 8;
  localparam int STATE_W    = 8;
  localparam int CMD_W      = 2;
  localparam int MOVE_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_W      = 8;

  localparam logic [POS_W-1:0] MID_POS  = POS_W'(TAPE_DEPTH / 2);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(TAPE_DEPTH - 1);

  localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PERFORM = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  localparam logic [MOVE_W-1:0] MV_STAY  = 2'd0;
  localparam logic [MOVE_W-1:0] MV_LEFT  = 2'd1;
  localparam logic [MOVE_W-1:0] MV_RIGHT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EDGE   = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_BLANK     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WILD_SYM  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WILD_EN   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KEEP_SYM  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KEEP_EN   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_INIT_ST   = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [STATE_W-1:0] source_state;
    logic [STATE_W-1:0] target_state;
    logic [SYM_W-1:0]   read_symbol_a;
    logic [SYM_W-1:0]   read_symbol_b;
    logic [SYM_W-1:0]   write_symbol_a;
    logic [SYM_W-1:0]   write_symbol_b;
    logic [MOVE_W-1:0]  move_a;
    logic [MOVE_W-1:0]  move_b;
  } in_item_t;

  typedef struct packed {
    logic                compatible;
    logic [STATUS_W-1:0] status;
    logic [STATE_W-1:0]  machine_state;
    logic [SYM_W-1:0]    head_symbol_a;
    logic [SYM_W-1:0]    head_symbol_b;
  } out_item_t;

  typedef struct packed {
    logic              apply;
    logic              restart;
    logic              write;
    logic [SYM_W-1:0]  wdata;
    logic [MOVE_W-1:0] mv;
  } tape_cmd_t;

  typedef struct packed {
    logic             edge_hit;
    logic [SYM_W-1:0] cur_sym;
    logic [SYM_W-1:0] new_sym;
  } tape_stat_t;

endpackage

/* rtl/mts_in_if.sv */
`timescale 1ns / 1ps

interface mts_in_if;
  import mts_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/mts_out_if.sv */
`timescale 1ns / 1ps

interface mts_out_if;
  import mts_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/mts_cfg_if.sv */
`timescale 1ns / 1ps

interface mts_cfg_if;
  import mts_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/mts_tape.sv */
`timescale 1ns / 1ps

module mts_tape (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [mts_pkg::SYM_W-1:0] blank,
  input  mts_pkg::tape_cmd_t        cmd,
  input  logic                      s2_valid,
  output mts_pkg::tape_stat_t       stat
);
  import mts_pkg::*;

  logic [SYM_W-1:0] mem [TAPE_DEPTH];
  logic [SYM_W-1:0] rdata;
  logic [SYM_W-1:0] hsym;
  logic [SYM_W-1:0] hsym_next;
  logic [SYM_W-1:0] s2_wdata;
  logic [SYM_W-1:0] mem_wdata;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] lo;
  logic [POS_W-1:0] hi;
  logic [POS_W-1:0] pos_new;
  logic             fresh;
  logic             go_left;
  logic             go_right;
  logic             at_low;
  logic             at_high;
  logic             moving;
  logic             new_cell;
  logic             mem_we;
  logic             s2_new_cell;
  logic             s2_use_rd;
  logic             s2_load;

  assign go_left  = cmd.mv == MV_LEFT;
  assign go_right = cmd.mv == MV_RIGHT;
  assign at_low   = pos == '0;
  assign at_high  = pos == LAST_POS;
  assign pos_new  = go_left ? pos - POS_W'(1) : pos + POS_W'(1);
  assign moving   = cmd.apply && ((go_left && !at_low) || (go_right && !at_high));
  assign new_cell = moving && (go_left ? (pos_new < lo) : (pos_new > hi));

  // S1 writes the item's symbol at the old head; S2 blanks a newly reached cell
  assign mem_we    = (cmd.apply && cmd.write) || (s2_valid && s2_new_cell);
  assign mem_wdata = s2_valid ? blank : cmd.wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pos] <= mem_wdata;
    end
    if (moving) begin
      rdata <= mem[pos_new];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= MID_POS;
      lo          <= MID_POS;
      hi          <= MID_POS;
      fresh       <= 1'b1;
      s2_new_cell <= 1'b0;
      s2_use_rd   <= 1'b0;
      s2_load     <= 1'b0;
    end else begin
      s2_new_cell <= new_cell;
      s2_use_rd   <= moving && !new_cell;
      s2_load     <= cmd.apply && cmd.write && !moving;
      if (cmd.restart) begin
        pos   <= MID_POS;
        lo    <= MID_POS;
        hi    <= MID_POS;
        fresh <= 1'b1;
      end else if (cmd.apply) begin
        if (cmd.write && pos == MID_POS) begin
          fresh <= 1'b0;
        end
        if (moving) begin
          pos <= pos_new;
        end
        if (new_cell && go_left) begin
          lo <= pos_new;
        end
        if (new_cell && go_right) begin
          hi <= pos_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_wdata <= cmd.wdata;
    hsym     <= hsym_next;
  end

  always_comb begin
    hsym_next = hsym;
    if (s2_valid) begin
      if (s2_new_cell) begin
        hsym_next = blank;
      end else if (s2_use_rd) begin
        hsym_next = rdata;
      end else if (s2_load) begin
        hsym_next = s2_wdata;
      end
    end
  end

  assign stat.edge_hit = cmd.apply && ((go_left && at_low) || (go_right && at_high));
  assign stat.cur_sym  = (fresh && pos == MID_POS) ? blank : hsym;
  assign stat.new_sym  = (fresh && pos == MID_POS) ? blank : hsym_next;

endmodule

/* rtl/mts_out_fifo.sv */
`timescale 1ns / 1ps

module mts_out_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mts_pkg::out_item_t push_data,
  output logic [1:0]         level,
  mts_out_if.source          result
);
  import mts_pkg::*;

  out_item_t store [2];
  logic      wptr;
  logic      rptr;
  logic      pop;

  assign pop          = result.valid && result.ready;
  assign result.valid = level != 2'd0;
  assign result.data  = store[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      level <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        level <= level + 2'd1;
      end else if (pop && !push) begin
        level <= level - 2'd1;
      end
    end
  end

endmodule

/* rtl/multitape_turing_step.sv */
`timescale 1ns / 1ps
// Items are registered into tape stage S1, then S2, which pushes the result
// into the output buffer. An item is taken only with S1 empty and buffer room,
// as its match needs the tape memory read of the cell under each moved head.
// Reset: control and config registers to 0, heads and spans to mid tape,
// start cells blank. Tape memory stays undefined; no clearing pass is run.

module multitape_turing_step (
  input  logic       clk,
  input  logic       rst,
  mts_in_if.sink     xfer,
  mts_out_if.source  result,
  mts_cfg_if.sink    cfg
);
  import mts_pkg::*;

  logic [SYM_W-1:0]    blank_symbol;
  logic [SYM_W-1:0]    wildcard_symbol;
  logic                wildcard_enable;
  logic [SYM_W-1:0]    keep_symbol;
  logic                keep_enable;
  logic [STATE_W-1:0]  initial_state;
  logic [STATE_W-1:0]  cur_state;

  in_item_t            s1_item;
  logic                s1_valid;
  logic                s2_valid;
  logic                s2_compat;
  logic [STATUS_W-1:0] s2_status;

  logic [SYM_W-1:0]    rd_sym [2];
  logic [SYM_W-1:0]    wr_sym [2];
  logic [MOVE_W-1:0]   mv     [2];
  tape_cmd_t           tcmd   [NUM_TAPES];
  tape_stat_t          tstat  [NUM_TAPES];

  logic                match;
  logic                any_edge;
  logic                is_restart;
  logic                is_perform;
  logic                apply;
  logic                compat;
  logic [STATUS_W-1:0] status;
  logic [1:0]          level;
  out_item_t           push_data;
  logic                accept;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_symbol    <= '0;
      wildcard_symbol <= '0;
      wildcard_enable <= 1'b0;
      keep_symbol     <= '0;
      keep_enable     <= 1'b0;
      initial_state   <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_BLANK:    blank_symbol    <= cfg.data[SYM_W-1:0];
        REG_WILD_SYM: wildcard_symbol <= cfg.data[SYM_W-1:0];
        REG_WILD_EN:  wildcard_enable <= cfg.data[0];
        REG_KEEP_SYM: keep_symbol     <= cfg.data[SYM_W-1:0];
        REG_KEEP_EN:  keep_enable     <= cfg.data[0];
        REG_INIT_ST:  initial_state   <= cfg.data[STATE_W-1:0];
        default: ;
      endcase
    end
  end

  // One item in the tape pipeline at a time; two output slots cover it.
  assign xfer.ready = !s1_valid && (level == 2'd0 || (level == 2'd1 && !s2_valid));
  assign accept     = xfer.valid && xfer.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= xfer.data;
    end
  end

  assign rd_sym[0] = s1_item.read_symbol_a;
  assign rd_sym[1] = s1_item.read_symbol_b;
  assign wr_sym[0] = s1_item.write_symbol_a;
  assign wr_sym[1] = s1_item.write_symbol_b;
  assign mv[0]     = s1_item.move_a;
  assign mv[1]     = s1_item.move_b;

  assign is_restart = s1_valid && s1_item.command == CMD_RESTART;
  assign is_perform = s1_valid && s1_item.command == CMD_PERFORM;

  always_comb begin
    match    = s1_item.source_state == cur_state;
    any_edge = 1'b0;
    for (int t = 0; t < NUM_TAPES; t++) begin
      if (tstat[t].cur_sym != rd_sym[t] &&
          !(wildcard_enable && rd_sym[t] == wildcard_symbol)) begin
        match = 1'b0;
      end
      any_edge = any_edge | tstat[t].edge_hit;
    end
  end

  assign apply  = is_perform && match;
  assign compat = !is_restart && match;

  always_comb begin
    status = ST_OK;
    if (is_perform && !match) begin
      status = ST_REJECT;
    end else if (any_edge) begin
      status = ST_EDGE;
    end
  end

  for (genvar t = 0; t < NUM_TAPES; t++) begin : g_tape
    assign tcmd[t].apply   = apply;
    assign tcmd[t].restart = is_restart;
    assign tcmd[t].write   = !(keep_enable && wr_sym[t] == keep_symbol);
    assign tcmd[t].wdata   = wr_sym[t];
    assign tcmd[t].mv      = mv[t];

    mts_tape u_tape (
      .clk      (clk),
      .rst      (rst),
      .blank    (blank_symbol),
      .cmd      (tcmd[t]),
      .s2_valid (s2_valid),
      .stat     (tstat[t])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      cur_state <= '0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      if (is_restart) begin
        cur_state <= initial_state;
      end else if (apply) begin
        cur_state <= s1_item.target_state;
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_compat <= compat;
    s2_status <= status;
  end

  assign push_data.compatible    = s2_compat;
  assign push_data.status        = s2_status;
  assign push_data.machine_state = cur_state;
  assign push_data.head_symbol_a = tstat[0].new_sym;

  if (NUM_TAPES > 1) begin : g_sym_b
    assign push_data.head_symbol_b = tstat[NUM_TAPES-1].new_sym;
  end else begin : g_no_b
    assign push_data.head_symbol_b = '0;
  end

  mts_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_valid),
    .push_data (push_data),
    .level     (level),
    .result    (result)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s1_valid && s2_valid))
    else $error("tape stages overlap");

  a_s1_to_s2: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> s2_valid)
    else $error("item lost between stages");

  a_accept_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid && !s2_valid)
    else $error("accepted item not in first stage");

  a_fifo_room: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (level != 2'd2 || result.ready))
    else $error("result buffer overflow");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import mts_pkg::*;

  localparam logic [CMD_W-1:0]     CMD_SPARE  = 2'd3;
  localparam logic [MOVE_W-1:0]    MV_SPARE   = 2'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPARE6 = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE7 = 3'd7;
  localparam int                   SETTLE_CYCLES = 8;

  typedef enum {STALL_NONE, STALL_COIN, STALL_MASK, STALL_RARE} stall_style_t;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } probe_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mts_in_if  xfer_ch ();
  mts_out_if result_ch ();
  mts_cfg_if cfg_ch ();

  multitape_turing_step dut (
    .clk    (clk),
    .rst    (rst),
    .xfer   (xfer_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #6 clk = ~clk;

  // machine copy
  logic [SYM_W-1:0]   tape_mem [NUM_TAPES][TAPE_DEPTH];
  logic [POS_W-1:0]   head_at  [NUM_TAPES];
  logic [POS_W-1:0]   span_lo  [NUM_TAPES];
  logic [POS_W-1:0]   span_hi  [NUM_TAPES];
  bit                 start_blank [NUM_TAPES];
  logic [STATE_W-1:0] mach_state;
  logic [SYM_W-1:0]   blank_sym, wild_sym, keep_sym;
  logic [STATE_W-1:0] restart_state;
  bit                 wild_on, keep_on;

  out_item_t outcome_q [$];
  probe_row_t probes [$];

  int n_items, n_checked, n_errors, n_rejects, n_edges, n_restarts, n_settings;
  int burst_left;

  function automatic logic [SYM_W-1:0] head_sym(int t);
    if (start_blank[t] && head_at[t] == MID_POS) return blank_sym;
    return tape_mem[t][head_at[t]];
  endfunction

  function automatic void rewind_tapes();
    for (int t = 0; t < NUM_TAPES; t++) begin
      head_at[t]     = MID_POS;
      span_lo[t]     = MID_POS;
      span_hi[t]     = MID_POS;
      start_blank[t] = 1'b1;
    end
    mach_state = restart_state;
  endfunction

  // true when the head would leave the tape
  function automatic bit shift_head(int t, logic [MOVE_W-1:0] mv);
    if (mv == MV_LEFT) begin
      if (head_at[t] == '0) return 1'b1;
      head_at[t] = head_at[t] - POS_W'(1);
      if (head_at[t] < span_lo[t]) begin
        span_lo[t] = head_at[t];
        tape_mem[t][head_at[t]] = blank_sym;
      end
    end else if (mv == MV_RIGHT) begin
      if (head_at[t] == LAST_POS) return 1'b1;
      head_at[t] = head_at[t] + POS_W'(1);
      if (head_at[t] > span_hi[t]) begin
        span_hi[t] = head_at[t];
        tape_mem[t][head_at[t]] = blank_sym;
      end
    end
    return 1'b0;
  endfunction

  function automatic out_item_t advance_machine(in_item_t it);
    logic [SYM_W-1:0]  rd [NUM_TAPES];
    logic [SYM_W-1:0]  wr [NUM_TAPES];
    logic [MOVE_W-1:0] mv [NUM_TAPES];
    out_item_t r;
    bit ok;
    rd[0] = it.read_symbol_a;
    rd[1] = it.read_symbol_b;
    wr[0] = it.write_symbol_a;
    wr[1] = it.write_symbol_b;
    mv[0] = it.move_a;
    mv[1] = it.move_b;
    r = '0;
    if (it.command == CMD_RESTART) begin
      rewind_tapes();
    end else begin
      ok = (mach_state == it.source_state);
      for (int t = 0; t < NUM_TAPES; t++)
        if (head_sym(t) != rd[t] && !(wild_on && rd[t] == wild_sym)) ok = 1'b0;
      r.compatible = ok;
      if (it.command == CMD_PERFORM) begin
        if (!ok) begin
          r.status = ST_REJECT;
        end else begin
          mach_state = it.target_state;
          for (int t = 0; t < NUM_TAPES; t++) begin
            if (!(keep_on && wr[t] == keep_sym)) begin
              tape_mem[t][head_at[t]] = wr[t];
              if (head_at[t] == MID_POS) start_blank[t] = 1'b0;
            end
            if (shift_head(t, mv[t])) r.status = ST_EDGE;
          end
        end
      end
    end
    r.machine_state = mach_state;
    r.head_symbol_a = head_sym(0);
    r.head_symbol_b = head_sym(1);
    return r;
  endfunction

  function automatic in_item_t mk_transition(logic [CMD_W-1:0] c, logic [STATE_W-1:0] s, d,
                                             logic [SYM_W-1:0] ra, rb, wa, wb,
                                             logic [MOVE_W-1:0] ma, mb);
    in_item_t it;
    it.command        = c;
    it.source_state   = s;
    it.target_state   = d;
    it.read_symbol_a  = ra;
    it.read_symbol_b  = rb;
    it.write_symbol_a = wa;
    it.write_symbol_b = wb;
    it.move_a         = ma;
    it.move_b         = mb;
    return it;
  endfunction

  function automatic out_item_t mk_outcome(logic c, logic [STATUS_W-1:0] st,
                                           logic [STATE_W-1:0] ms, logic [SYM_W-1:0] ha, hb);
    out_item_t r;
    r.compatible    = c;
    r.status        = st;
    r.machine_state = ms;
    r.head_symbol_a = ha;
    r.head_symbol_b = hb;
    return r;
  endfunction

  // mostly transitions that match, so the tapes actually get walked
  function automatic in_item_t random_transition();
    logic [CMD_W-1:0]  cmds  [4];
    logic [MOVE_W-1:0] moves [4];
    in_item_t it;
    int pick;
    cmds  = '{CMD_RESTART, CMD_SPARE, CMD_PERFORM, CMD_CHECK};
    moves = '{MV_STAY, MV_LEFT, MV_RIGHT, MV_SPARE};
    pick = $urandom_range(0, 99);
    it.command = (pick < 7) ? cmds[0] : (pick < 11) ? cmds[1] : (pick < 75) ? cmds[2] : cmds[3];
    it.source_state = ($urandom_range(0, 9) != 0) ? mach_state : STATE_W'($urandom);
    it.target_state = STATE_W'($urandom);
    pick = $urandom_range(0, 9);
    it.read_symbol_a = (pick < 7) ? head_sym(0) : (pick < 8) ? wild_sym : SYM_W'($urandom);
    pick = $urandom_range(0, 9);
    it.read_symbol_b = (pick < 7) ? head_sym(1) : (pick < 8) ? wild_sym : SYM_W'($urandom);
    it.write_symbol_a = ($urandom_range(0, 6) == 0) ? keep_sym : SYM_W'($urandom);
    it.write_symbol_b = ($urandom_range(0, 6) == 0) ? keep_sym : SYM_W'($urandom);
    it.move_a = ($urandom_range(0, 9) == 0) ? moves[3] : moves[$urandom_range(0, 2)];
    it.move_b = ($urandom_range(0, 9) == 0) ? moves[3] : moves[$urandom_range(0, 2)];
    return it;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endfunction

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        xfer_ch.valid <= 1'b0;
      end
    end
  endtask

  task automatic offer_transition(in_item_t it, bit typed = 1'b0, out_item_t typed_res = '0);
    out_item_t predicted;
    @(negedge clk);
    xfer_ch.valid <= 1'b1;
    xfer_ch.data  <= it;
    do @(posedge clk); while (!xfer_ch.ready);
    predicted = advance_machine(it);
    outcome_q.insert(outcome_q.size(), typed ? typed_res : predicted);
    n_items++;
    if (it.command == CMD_RESTART) n_restarts++;
    if (predicted.status == ST_REJECT) n_rejects++;
    if (predicted.status == ST_EDGE) n_edges++;
    pace_sender();
  endtask

  task automatic drain_results();
    @(negedge clk);
    xfer_ch.valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  task automatic load_settings(logic [CFG_W-1:0] b, ws, we, ks, ke, is);
    logic [REG_IDX_W-1:0] idx [8];
    logic [CFG_W-1:0]     val [8];
    idx = '{REG_BLANK, REG_WILD_SYM, REG_WILD_EN, REG_KEEP_SYM, REG_KEEP_EN, REG_INIT_ST,
            REG_SPARE6, REG_SPARE7};
    val = '{b, ws, we, ks, ke, is, CFG_W'($urandom), CFG_W'($urandom)};
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= val[i];
      do @(posedge clk); while (!cfg_ch.ready);
      case (idx[i])
        REG_BLANK:    blank_sym     = val[i];
        REG_WILD_SYM: wild_sym      = val[i];
        REG_WILD_EN:  wild_on       = val[i][0];
        REG_KEEP_SYM: keep_sym      = val[i];
        REG_KEEP_EN:  keep_on       = val[i][0];
        REG_INIT_ST:  restart_state = val[i];
        default: ;
      endcase
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    n_settings++;
  endtask

  task automatic run_random(int count, int pause_at = -1);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) drain_results();
      offer_transition(random_transition());
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (outcome_q.size() == 0) begin
        $error("result item with no transition outstanding: %p", result_ch.data);
        n_errors++;
      end else begin
        want = outcome_q[0];
        outcome_q.delete(0);
        n_checked++;
        check_field("compatible", 32'(want.compatible), 32'(result_ch.data.compatible));
        check_field("status", 32'(want.status), 32'(result_ch.data.status));
        check_field("machine_state", 32'(want.machine_state),
                    32'(result_ch.data.machine_state));
        check_field("head_symbol_a", 32'(want.head_symbol_a),
                    32'(result_ch.data.head_symbol_a));
        check_field("head_symbol_b", 32'(want.head_symbol_b),
                    32'(result_ch.data.head_symbol_b));
      end
    end
  end

  initial begin : receiver
    stall_style_t style;
    int style_left, hold_left, next_hold;
    logic [7:0] mask;
    style      = STALL_NONE;
    style_left = 0;
    hold_left  = 0;
    next_hold  = 350;
    mask       = 8'hFF;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      // long hold-off so the block backs up into its input
      if (next_hold != 0 && n_checked >= next_hold) begin
        hold_left = 400;
        next_hold = (next_hold < 1000) ? 1000 : 0;
      end
      if (style_left == 0) begin
        style      = stall_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(16, 128);
        mask       = 8'($urandom) | 8'h01;
      end
      style_left--;
      if (hold_left != 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        case (style)
          STALL_NONE: result_ch.ready <= 1'b1;
          STALL_COIN: result_ch.ready <= 1'($urandom_range(0, 1));
          STALL_MASK: result_ch.ready <= mask[style_left % 8];
          default:    result_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    in_item_t it;
    xfer_ch.valid = 1'b0;
    xfer_ch.data  = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    blank_sym     = '0;
    wild_sym      = '0;
    wild_on       = 1'b0;
    keep_sym      = '0;
    keep_on       = 1'b0;
    restart_state = '0;
    burst_left    = 0;
    rewind_tapes();

    probes.insert(probes.size(),
                  '{mk_transition(CMD_CHECK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                  MV_STAY, MV_STAY), 1'b1,
                    mk_outcome(1'b1, ST_OK, 8'h00, 8'h00, 8'h00)});
    probes.insert(probes.size(),
                  '{mk_transition(CMD_CHECK, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
                                  MV_STAY, MV_STAY), 1'b1,
                    mk_outcome(1'b0, ST_OK, 8'h00, 8'h00, 8'h00)});
    probes.insert(probes.size(),
                  '{mk_transition(CMD_CHECK, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00,
                                  MV_STAY, MV_STAY), 1'b1,
                    mk_outcome(1'b0, ST_OK, 8'h00, 8'h00, 8'h00)});
    probes.insert(probes.size(),
                  '{mk_transition(CMD_CHECK, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00,
                                  MV_STAY, MV_STAY), 1'b1,
                    mk_outcome(1'b0, ST_OK, 8'h00, 8'h00, 8'h00)});
    probes.insert(probes.size(),
                  '{mk_transition(CMD_PERFORM, 8'hFF, 8'h12, 8'h00, 8'h00, 8'h34, 8'h56,
                                  MV_LEFT, MV_RIGHT), 1'b1,
                    mk_outcome(1'b0, ST_REJECT, 8'h00, 8'h00, 8'h00)});
    probes.insert(probes.size(),
                  '{mk_transition(CMD_PERFORM, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00,
                                  MV_LEFT, MV_RIGHT), 1'b0, '0});
    probes.insert(probes.size(),
                  '{mk_transition(CMD_PERFORM, 8'hFF, 8'h5A, 8'h00, 8'h00, 8'hAA, 8'h55,
                                  MV_RIGHT, MV_LEFT), 1'b0, '0});
    probes.insert(probes.size(),
                  '{mk_transition(CMD_SPARE, 8'h5A, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00,
                                  MV_STAY, MV_STAY), 1'b0, '0});
    probes.insert(probes.size(),
                  '{mk_transition(CMD_PERFORM, 8'h5A, 8'hC3, 8'hFF, 8'h00, 8'h01, 8'h80,
                                  MV_SPARE, MV_SPARE), 1'b0, '0});
    probes.insert(probes.size(),
                  '{mk_transition(CMD_PERFORM, 8'hC3, 8'h00, 8'h01, 8'h80, 8'hFF, 8'hFF,
                                  MV_RIGHT, MV_RIGHT), 1'b0, '0});
    probes.insert(probes.size(),
                  '{mk_transition(CMD_RESTART, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                  MV_SPARE, MV_SPARE), 1'b1,
                    mk_outcome(1'b0, ST_OK, 8'h00, 8'h00, 8'h00)});
    probes.insert(probes.size(),
                  '{mk_transition(CMD_PERFORM, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h0F, 8'hF0,
                                  MV_STAY, MV_STAY), 1'b0, '0});
    probes.insert(probes.size(),
                  '{mk_transition(CMD_CHECK, 8'hFF, 8'h00, 8'h0F, 8'hF0, 8'h00, 8'h00,
                                  MV_STAY, MV_STAY), 1'b0, '0});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (probes[i]) offer_transition(probes[i].item, probes[i].typed, probes[i].res);
    run_random(200);

    // wildcard and keep on, then walk both heads off opposite ends
    load_settings(8'hFF, 8'h00, {7'($urandom), 1'b1}, 8'hFF, {7'($urandom), 1'b1}, 8'hFF);
    offer_transition(mk_transition(CMD_RESTART, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                   MV_STAY, MV_STAY));
    for (int i = 0; i < 516; i++) begin
      it = random_transition();
      it.command       = CMD_PERFORM;
      it.source_state  = mach_state;
      it.read_symbol_a = wild_sym;
      it.read_symbol_b = wild_sym;
      it.move_a        = MV_LEFT;
      it.move_b        = MV_RIGHT;
      offer_transition(it);
    end
    run_random(200);

    load_settings(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                  CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
    run_random(300, 150);

    load_settings(8'hA5, 8'hFF, {7'($urandom), 1'b0}, 8'h00, {7'($urandom), 1'b1}, 8'h00);
    run_random(200);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d transitions: %0d restarts, %0d rejected, %0d at a tape edge.",
             n_items, n_restarts, n_rejects, n_edges);
    $display("%0d register settings applied, %0d result items compared.",
             n_settings, n_checked);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* multitape_turing_step.f */
rtl/mts_pkg.sv
rtl/mts_in_if.sv
rtl/mts_out_if.sv
rtl/mts_cfg_if.sv
rtl/mts_tape.sv
rtl/mts_out_fifo.sv
rtl/multitape_turing_step.sv
tb/sv/testbench.sv
